FILE: sv/tfn_pkg.sv
// Shared types and constants for the triangle face normal unit.
package tfn_pkg;

  // Width of a scaled cross product magnitude, with the largest one in [2^30, 2^31).
  localparam int MAG_W = 31;
  // Width of the squared length and of the integer root.
  localparam int SUM_W = 64;
  localparam int ROOT_W = 32;
  // Width of the square root partial remainder.
  localparam int SREM_W = 35;
  // Width of each output component.
  localparam int OUT_W = 16;
  // Widest edge that keeps the cross product inside 64 bits.
  localparam int MAX_EDGE_W = 30;

  // Per-item flags that travel along with the data.
  typedef struct packed {
    logic [2:0] neg;    // sign of each cross product component, x in bit 0
    logic       degen;  // cross product is the zero vector
  } tfn_aux_t;

endpackage

FILE: sv/triangle_face_normal_unit_core.sv
// Top level of the triangle face normal unit: streaming pipeline of arithmetic cells.
// Takes one triangle per cycle while the output is not stalled and returns its unit face
// normal in signed Q1.NORMAL_FRAC_BITS. The length comes from a row of 32 square root
// cells, one root bit each, and each component from a row of NORMAL_FRAC_BITS + 1
// divider cells, one quotient bit each. The whole pipeline advances together whenever
// the output register is empty or being taken, so a stalled output holds every item
// in place. A degenerate triangle returns a zero normal with tuser set.
module triangle_face_normal_unit_core #(
  parameter int COORD_BITS       = 16,
  parameter int NORMAL_FRAC_BITS = 14
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // Fields from bit 0 up: ax, ay, az, bx, by, bz, cx, cy, cz, zero fill.
  input  logic [((9*COORD_BITS+7)/8)*8-1:0]    s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // Fields from bit 0 up: nx, ny, nz.
  output logic [3*tfn_pkg::OUT_W-1:0]          m_axis_tdata,
  // Fields from bit 0 up: degenerate.
  output logic                                 m_axis_tuser
);

  localparam int CW  = COORD_BITS;
  localparam int FB  = NORMAL_FRAC_BITS;
  localparam int ES  = (CW + 1 > tfn_pkg::MAX_EDGE_W) ? tfn_pkg::MAX_EDGE_W : CW + 1;
  localparam int XW  = 2 * ES + 1;
  localparam int W   = (XW > tfn_pkg::MAG_W) ? XW : tfn_pkg::MAG_W;
  localparam int NS  = $clog2(W);
  localparam int MW  = tfn_pkg::MAG_W;
  localparam int RW  = tfn_pkg::ROOT_W;
  localparam int QN  = FB + 1;
  localparam int DW  = MW + 1 + FB;
  localparam int NSQ = RW;
  localparam int PLW = 3 * MW + $bits(tfn_pkg::tfn_aux_t);

  logic en;

  // Unpack the triangle.
  logic [2:0][CW-1:0] va, vb, vc;
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      va[j] = s_axis_tdata[j*CW +: CW];
      vb[j] = s_axis_tdata[(3+j)*CW +: CW];
      vc[j] = s_axis_tdata[(6+j)*CW +: CW];
    end
  end

  // Edges and cross product.
  logic               cr_valid;
  logic [2:0][XW-1:0] cr_mag;
  tfn_pkg::tfn_aux_t  cr_aux;

  tfn_cross #(.CW(CW), .ES(ES)) u_cross (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .a_i     (va),
    .b_i     (vb),
    .c_i     (vc),
    .valid_o (cr_valid),
    .mag_o   (cr_mag),
    .aux_o   (cr_aux)
  );

  // Block normalizer chain, largest shift first.
  logic              nm_valid [NS+1];
  logic [2:0][W-1:0] nm_mag   [NS+1];
  tfn_pkg::tfn_aux_t nm_aux   [NS+1];

  always_comb begin
    nm_valid[0] = cr_valid;
    nm_aux[0]   = cr_aux;
    for (int j = 0; j < 3; j++) begin
      nm_mag[0][j] = W'(cr_mag[j]);
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_norm
    tfn_norm_cell #(.W(W), .SH(1 << (NS - 1 - i))) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (nm_valid[i]),
      .mag_i   (nm_mag[i]),
      .aux_i   (nm_aux[i]),
      .valid_o (nm_valid[i+1]),
      .mag_o   (nm_mag[i+1]),
      .aux_o   (nm_aux[i+1])
    );
  end

  // Scaled magnitudes are the top bits of the normalized words.
  logic [2:0][MW-1:0] sm;
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      sm[j] = nm_mag[NS][j][W-1 -: MW];
    end
  end

  // Squares of the scaled magnitudes.
  logic                   sq_valid_q;
  logic [2*MW-1:0]        sq_q [3];
  logic [2:0][MW-1:0]     sq_m_q;
  tfn_pkg::tfn_aux_t      sq_aux_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_valid_q <= 1'b0;
    end else if (en) begin
      sq_valid_q <= nm_valid[NS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        sq_q[j] <= sm[j] * sm[j];
      end
      sq_m_q   <= sm;
      sq_aux_q <= nm_aux[NS];
    end
  end

  // Sum of squares, the radicand.
  logic                    sum_valid_q;
  logic [tfn_pkg::SUM_W-1:0] sum_q;
  logic [PLW-1:0]          sum_pay_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_valid_q <= 1'b0;
    end else if (en) begin
      sum_valid_q <= sq_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sum_q     <= tfn_pkg::SUM_W'(sq_q[0]) + tfn_pkg::SUM_W'(sq_q[1])
                 + tfn_pkg::SUM_W'(sq_q[2]);
      sum_pay_q <= {sq_m_q, sq_aux_q};
    end
  end

  // Square root chain, one root bit per cell.
  logic                        rt_valid [NSQ+1];
  logic [tfn_pkg::SUM_W-1:0]   rt_x     [NSQ+1];
  logic [tfn_pkg::SREM_W-1:0]  rt_rem   [NSQ+1];
  logic [RW-1:0]               rt_root  [NSQ+1];
  logic [PLW-1:0]              rt_pay   [NSQ+1];

  always_comb begin
    rt_valid[0] = sum_valid_q;
    rt_x[0]     = sum_q;
    rt_rem[0]   = '0;
    rt_root[0]  = '0;
    rt_pay[0]   = sum_pay_q;
  end

  for (genvar i = 0; i < NSQ; i++) begin : g_sqrt
    tfn_sqrt_cell #(.PW(PLW)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (rt_valid[i]),
      .x_i     (rt_x[i]),
      .rem_i   (rt_rem[i]),
      .root_i  (rt_root[i]),
      .pay_i   (rt_pay[i]),
      .valid_o (rt_valid[i+1]),
      .x_o     (rt_x[i+1]),
      .rem_o   (rt_rem[i+1]),
      .root_o  (rt_root[i+1]),
      .pay_o   (rt_pay[i+1])
    );
  end

  // Dividend setup: m * 2^FB + L/2, split into a starting remainder and low bits.
  logic [2:0][MW-1:0] rt_m;
  tfn_pkg::tfn_aux_t  rt_aux;
  logic [DW-1:0]      dividend [3];

  always_comb begin
    {rt_m, rt_aux} = rt_pay[NSQ];
    for (int j = 0; j < 3; j++) begin
      dividend[j] = {1'b0, rt_m[j], FB'(0)} + DW'(rt_root[NSQ] >> 1);
    end
  end

  logic                    dv_valid [QN+1];
  logic [2:0][RW-1:0]      dv_rem   [QN+1];
  logic [2:0][QN-1:0]      dv_low   [QN+1];
  logic [2:0][QN-1:0]      dv_quo   [QN+1];
  logic [RW-1:0]           dv_len   [QN+1];
  tfn_pkg::tfn_aux_t       dv_aux   [QN+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_valid[0] <= 1'b0;
    end else if (en) begin
      dv_valid[0] <= rt_valid[NSQ];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        dv_rem[0][j] <= RW'(dividend[j][DW-1:QN]);
        dv_low[0][j] <= dividend[j][QN-1:0];
        dv_quo[0][j] <= '0;
      end
      dv_len[0] <= rt_root[NSQ];
      dv_aux[0] <= rt_aux;
    end
  end

  // Divider chain, one quotient bit per cell.
  for (genvar i = 0; i < QN; i++) begin : g_div
    tfn_div_cell #(.QN(QN)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (dv_valid[i]),
      .rem_i   (dv_rem[i]),
      .low_i   (dv_low[i]),
      .quo_i   (dv_quo[i]),
      .len_i   (dv_len[i]),
      .aux_i   (dv_aux[i]),
      .valid_o (dv_valid[i+1]),
      .rem_o   (dv_rem[i+1]),
      .low_o   (dv_low[i+1]),
      .quo_o   (dv_quo[i+1]),
      .len_o   (dv_len[i+1]),
      .aux_o   (dv_aux[i+1])
    );
  end

  // Saturate, apply the sign and clear degenerate results.
  logic [QN-1:0]               one_val;
  logic [31:0]                 nwide [3];
  logic [3*tfn_pkg::OUT_W-1:0] out_d;

  always_comb begin
    one_val = QN'(1) << FB;
    for (int j = 0; j < 3; j++) begin
      nwide[j] = (dv_quo[QN][j] > one_val) ? 32'(one_val) : 32'(dv_quo[QN][j]);
      if (dv_aux[QN].neg[j]) begin
        nwide[j] = 32'd0 - nwide[j];
      end
      if (dv_aux[QN].degen) begin
        nwide[j] = '0;
      end
      out_d[j*tfn_pkg::OUT_W +: tfn_pkg::OUT_W] = nwide[j][tfn_pkg::OUT_W-1:0];
    end
  end

  // Output register.
  logic out_valid_q;

  assign en = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dv_valid[QN];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_axis_tdata <= out_d;
      m_axis_tuser <= dv_aux[QN].degen;
    end
  end

  // A degenerate triangle always leaves as a zero normal.
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("degenerate item with a nonzero normal");

  // After normalization the largest magnitude has its top bit set.
  a_norm_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nm_valid[NS] && !nm_aux[NS].degen
      |-> (sm[0][MW-1] || sm[1][MW-1] || sm[2][MW-1]))
    else $error("block normalizer left the magnitudes unaligned");

  // The root is at least 2^30, the remainder shows it is the floor, the radicand is spent.
  a_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rt_valid[NSQ] && !rt_aux.degen
      |-> rt_root[NSQ][RW-1:RW-2] != 2'b00
          && rt_rem[NSQ] <= {2'b00, rt_root[NSQ], 1'b0}
          && rt_x[NSQ] == '0)
    else $error("square root out of range");

  // Each division ends with a remainder below the length and no dividend bits left.
  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_valid[QN] && !dv_aux[QN].degen
      |-> dv_rem[QN][0] < dv_len[QN] && dv_rem[QN][1] < dv_len[QN]
          && dv_rem[QN][2] < dv_len[QN] && dv_low[QN] == '0)
    else $error("division remainder out of range");

endmodule

FILE: sv/tfn_cross.sv
// Edge vectors, exact cross product and component magnitudes over two stages.
module tfn_cross #(
  parameter int CW = 16,
  parameter int ES = 17
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [2:0][CW-1:0]        a_i,
  input  logic [2:0][CW-1:0]        b_i,
  input  logic [2:0][CW-1:0]        c_i,
  output logic                      valid_o,
  output logic [2:0][2*ES:0]        mag_o,
  output tfn_pkg::tfn_aux_t         aux_o
);

  localparam int EW = CW + 1;
  localparam int XW = 2 * ES + 1;

  logic signed [EW-1:0]     e1 [3];
  logic signed [EW-1:0]     e2 [3];
  logic signed [ES-1:0]     e1t [3];
  logic signed [ES-1:0]     e2t [3];
  logic signed [2*ES-1:0]   prod_d [6];
  logic signed [2*ES-1:0]   prod_q [6];
  logic                     pv_q;
  logic signed [XW-1:0]     cr [3];
  logic [2:0][XW-1:0]       mag_d;
  tfn_pkg::tfn_aux_t        aux_d;

  // Edges from the first vertex; wide edges keep only their top bits (floor shift).
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      e1[j]  = $signed({b_i[j][CW-1], b_i[j]}) - $signed({a_i[j][CW-1], a_i[j]});
      e2[j]  = $signed({c_i[j][CW-1], c_i[j]}) - $signed({a_i[j][CW-1], a_i[j]});
      e1t[j] = e1[j][EW-1 -: ES];
      e2t[j] = e2[j][EW-1 -: ES];
    end
  end

  // The six partial products of the cross product.
  always_comb begin
    prod_d[0] = e1t[1] * e2t[2];
    prod_d[1] = e1t[2] * e2t[1];
    prod_d[2] = e1t[2] * e2t[0];
    prod_d[3] = e1t[0] * e2t[2];
    prod_d[4] = e1t[0] * e2t[1];
    prod_d[5] = e1t[1] * e2t[0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else if (en_i) begin
      pv_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  // Differences, magnitudes and signs of the three components.
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      cr[j] = $signed({prod_q[2*j][2*ES-1], prod_q[2*j]})
            - $signed({prod_q[2*j+1][2*ES-1], prod_q[2*j+1]});
      mag_d[j] = cr[j][XW-1] ? XW'(-cr[j]) : XW'(cr[j]);
      aux_d.neg[j] = cr[j][XW-1];
    end
    aux_d.degen = (cr[0] == '0) && (cr[1] == '0) && (cr[2] == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= pv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_o <= mag_d;
      aux_o <= aux_d;
    end
  end

endmodule

FILE: sv/tfn_norm_cell.sv
// One step of the block normalizer: shifts all three magnitudes left by a fixed amount or not at all.
module tfn_norm_cell #(
  parameter int W  = 35,
  parameter int SH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [2:0][W-1:0]    mag_i,
  input  tfn_pkg::tfn_aux_t    aux_i,
  output logic                 valid_o,
  output logic [2:0][W-1:0]    mag_o,
  output tfn_pkg::tfn_aux_t    aux_o
);

  logic [W-1:0]       any_bits;
  logic [2:0][W-1:0]  mag_d;

  // The common shift is taken when the top bits of every magnitude are clear.
  always_comb begin
    any_bits = mag_i[0] | mag_i[1] | mag_i[2];
    for (int j = 0; j < 3; j++) begin
      mag_d[j] = (any_bits[W-1 -: SH] == '0) ? (mag_i[j] << SH) : mag_i[j];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_o <= mag_d;
      aux_o <= aux_i;
    end
  end

endmodule

FILE: sv/tfn_sqrt_cell.sv
// One digit of the integer square root: settles one root bit per cell.
module tfn_sqrt_cell #(
  parameter int PW = 97
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [tfn_pkg::SUM_W-1:0]     x_i,
  input  logic [tfn_pkg::SREM_W-1:0]    rem_i,
  input  logic [tfn_pkg::ROOT_W-1:0]    root_i,
  input  logic [PW-1:0]                 pay_i,
  output logic                          valid_o,
  output logic [tfn_pkg::SUM_W-1:0]     x_o,
  output logic [tfn_pkg::SREM_W-1:0]    rem_o,
  output logic [tfn_pkg::ROOT_W-1:0]    root_o,
  output logic [PW-1:0]                 pay_o
);

  logic [tfn_pkg::SREM_W-1:0] shifted;
  logic [tfn_pkg::SREM_W-1:0] trial;
  logic                       fits;

  // Bring in the next two radicand bits and try the next root bit.
  always_comb begin
    shifted = {rem_i[tfn_pkg::SREM_W-3:0], x_i[tfn_pkg::SUM_W-1 -: 2]};
    trial   = {1'b0, root_i, 2'b01};
    fits    = (shifted >= trial);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_o    <= {x_i[tfn_pkg::SUM_W-3:0], 2'b00};
      rem_o  <= fits ? (shifted - trial) : shifted;
      root_o <= {root_i[tfn_pkg::ROOT_W-2:0], fits};
      pay_o  <= pay_i;
    end
  end

endmodule

FILE: sv/tfn_div_cell.sv
// One quotient bit of the three component divisions by the length.
module tfn_div_cell #(
  parameter int QN = 15
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            valid_i,
  input  logic [2:0][tfn_pkg::ROOT_W-1:0] rem_i,
  input  logic [2:0][QN-1:0]              low_i,
  input  logic [2:0][QN-1:0]              quo_i,
  input  logic [tfn_pkg::ROOT_W-1:0]      len_i,
  input  tfn_pkg::tfn_aux_t               aux_i,
  output logic                            valid_o,
  output logic [2:0][tfn_pkg::ROOT_W-1:0] rem_o,
  output logic [2:0][QN-1:0]              low_o,
  output logic [2:0][QN-1:0]              quo_o,
  output logic [tfn_pkg::ROOT_W-1:0]      len_o,
  output tfn_pkg::tfn_aux_t               aux_o
);

  logic [tfn_pkg::ROOT_W:0]          part [3];
  logic [2:0]                        fits;
  logic [2:0][tfn_pkg::ROOT_W-1:0]   rem_d;

  // Restoring division step on each lane; the remainder stays below the length.
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      part[j]  = {rem_i[j], low_i[j][QN-1]};
      fits[j]  = (part[j] >= {1'b0, len_i});
      rem_d[j] = fits[j] ? tfn_pkg::ROOT_W'(part[j] - {1'b0, len_i})
                         : tfn_pkg::ROOT_W'(part[j]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < 3; j++) begin
        rem_o[j] <= rem_d[j];
        low_o[j] <= {low_i[j][QN-2:0], 1'b0};
        quo_o[j] <= {quo_i[j][QN-2:0], fits[j]};
      end
      len_o <= len_i;
      aux_o <= aux_i;
    end
  end

endmodule
